>>> sv/restoring_integer_divider_macros.svh
// Assertion helpers shared by the divider RTL.
// Each macro expects clk and arst_n in scope.
`ifndef RESTORING_INTEGER_DIVIDER_MACROS_SVH
`define RESTORING_INTEGER_DIVIDER_MACROS_SVH

// Same-cycle implication.
`define RID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rid_pkg.sv
package rid_pkg;

	localparam int DW = 32;

	// Special case a division falls into, decided at the front of the pipe.
	typedef enum logic [1:0] {
		KIND_NORMAL    = 2'd0,
		KIND_ZERO_ZERO = 2'd1,
		KIND_ZERO_DIV  = 2'd2
	} rid_kind_t;

	typedef struct packed {
		logic          func;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} rid_op_t;

	// Payload handed from cell to cell.
	// acc starts as the dividend magnitude and fills up with quotient bits from the right.
	typedef struct packed {
		rid_kind_t     kind;
		logic          neg_q;
		logic          neg_r;
		logic [DW-1:0] rem;
		logic [DW-1:0] acc;
		logic [DW-1:0] den;
	} rid_data_t;

	typedef struct packed {
		logic [DW-1:0] quotient;
		logic [DW-1:0] remainder;
		logic          zero_divisor;
	} rid_res_t;

endpackage

>>> sv/rid_ifs.sv
interface rid_in_if;
	import rid_pkg::*;
	logic          valid;
	logic          ready;
	logic          func;
	logic [DW-1:0] dividend;
	logic [DW-1:0] divisor;

	modport source (output valid, output func, output dividend, output divisor, input ready);
	modport sink   (input valid, input func, input dividend, input divisor, output ready);
endinterface

interface rid_out_if;
	import rid_pkg::*;
	logic          valid;
	logic          ready;
	logic [DW-1:0] quotient;
	logic [DW-1:0] remainder;
	logic          zero_divisor;

	modport source (output valid, output quotient, output remainder, output zero_divisor,
		input ready);
	modport sink   (input valid, input quotient, input remainder, input zero_divisor,
		output ready);
endinterface

>>> sv/rid_prep.sv
module rid_prep import rid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid,
	input  rid_op_t   op,
	output logic      valid_q,
	output rid_data_t data_q
);

	logic          a_neg;
	logic          b_neg;
	logic [DW-1:0] a_mag;
	logic [DW-1:0] b_mag;
	rid_data_t     data_d;

	always_comb begin
		a_neg = op.func & op.dividend[DW-1];
		b_neg = op.func & op.divisor[DW-1];
		a_mag = a_neg ? (~op.dividend + {{(DW-1){1'b0}}, 1'b1}) : op.dividend;
		b_mag = b_neg ? (~op.divisor + {{(DW-1){1'b0}}, 1'b1}) : op.divisor;
		data_d.rem   = '0;
		data_d.acc   = a_mag;
		data_d.den   = b_mag;
		data_d.neg_q = a_neg ^ b_neg;
		data_d.neg_r = a_neg;
		if (op.divisor != '0) begin
			data_d.kind = KIND_NORMAL;
		end else if (op.dividend == '0) begin
			data_d.kind = KIND_ZERO_ZERO;
		end else begin
			data_d.kind = KIND_ZERO_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
		end
	end

endmodule

>>> sv/rid_cell.sv
module rid_cell import rid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid,
	input  rid_data_t data,
	output logic      valid_q,
	output rid_data_t data_q
);

	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          ge;
	rid_data_t     data_d;

	// One restoring step: shift in the next dividend bit, try the subtract.
	always_comb begin
		rem_sh = {data.rem, data.acc[DW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, data.den};
		ge     = ~diff[DW+1];
		data_d     = data;
		data_d.rem = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
		data_d.acc = {data.acc[DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
		end
	end

endmodule

>>> sv/rid_post.sv
module rid_post import rid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid,
	input  rid_data_t data,
	output logic      valid_q,
	output rid_res_t  res_q
);

	rid_res_t res_d;

	always_comb begin
		res_d.zero_divisor = 1'b0;
		res_d.quotient     = data.neg_q ? (~data.acc + {{(DW-1){1'b0}}, 1'b1}) : data.acc;
		res_d.remainder    = data.neg_r ? (~data.rem + {{(DW-1){1'b0}}, 1'b1}) : data.rem;
		case (data.kind)
			KIND_ZERO_ZERO: begin
				res_d.quotient  = {{(DW-1){1'b0}}, 1'b1};
				res_d.remainder = '0;
			end
			KIND_ZERO_DIV: begin
				res_d.quotient     = '1;
				res_d.remainder    = '1;
				res_d.zero_divisor = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

endmodule

>>> sv/restoring_integer_divider.sv
// Pipelined restoring divider, 32-bit, signed or unsigned.
// req carries func (0 unsigned, 1 signed), dividend and divisor; rsp carries
// quotient, remainder and zero_divisor. Both use valid/ready; a transfer
// happens on a rising clk edge with valid and ready high.
// A new operation is taken every cycle while rsp is not stalled: the divide
// runs down a row of 32 identical cells, one quotient bit per cell, so many
// operations are in flight at once and results leave in order.
// A req transfer reaches rsp.valid through one operand stage that forms
// magnitudes and classifies zero divisors, 32 cells, and one result stage
// that applies signs and is the output register.
// When rsp.ready is low with a result waiting, the whole pipe holds and
// req.ready drops in the same cycle; nothing is dropped or repeated.
// Divide by zero with a nonzero dividend returns all ones and zero_divisor;
// 0/0 returns quotient 1 and remainder 0. Signed remainders take the sign of
// the dividend.
// arst_n clears every stage valid bit; the pipe is empty right after reset.
`include "restoring_integer_divider_macros.svh"

module restoring_integer_divider import rid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rid_in_if.sink    req,
	rid_out_if.source rsp
);

	// Stage 0 is the operand stage, stage DW the last cell.
	logic      stage_valid [DW+1];
	rid_data_t stage_data  [DW+1];
	logic [DW:0] valid_vec;
	logic      en;
	logic      out_valid_q;
	rid_res_t  res_q;
	rid_op_t   op;

	// Advance the whole pipe unless a result sits unaccepted.
	assign en        = ~out_valid_q | rsp.ready;
	assign req.ready = en;

	assign op.func     = req.func;
	assign op.dividend = req.dividend;
	assign op.divisor  = req.divisor;

	rid_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (req.valid),
		.op      (op),
		.valid_q (stage_valid[0]),
		.data_q  (stage_data[0])
	);

	for (genvar g = 0; g < DW; g++) begin : g_cell
		rid_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (stage_valid[g]),
			.data    (stage_data[g]),
			.valid_q (stage_valid[g+1]),
			.data_q  (stage_data[g+1])
		);
	end

	for (genvar v = 0; v <= DW; v++) begin : g_vvec
		assign valid_vec[v] = stage_valid[v];
	end

	rid_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid   (stage_valid[DW]),
		.data    (stage_data[DW]),
		.valid_q (out_valid_q),
		.res_q   (res_q)
	);

	assign rsp.valid        = out_valid_q;
	assign rsp.quotient     = res_q.quotient;
	assign rsp.remainder    = res_q.remainder;
	assign rsp.zero_divisor = res_q.zero_divisor;

	// A stalled output freezes every stage.
	`RID_ASSERT_NEXT(a_stall_holds, out_valid_q && !rsp.ready, $stable(valid_vec),
		"pipe moved while output stalled")
	// A request transfer lands in the operand stage.
	`RID_ASSERT_NEXT(a_accept_enters, req.valid && req.ready, stage_valid[0],
		"accepted operation did not enter the pipe")
	// Zero divisor results are all ones.
	`RID_ASSERT_NOW(a_zero_div_ones, out_valid_q && res_q.zero_divisor,
		res_q.quotient == '1 && res_q.remainder == '1,
		"zero divisor result not all ones")
	// The last cell moves into the output register when the pipe advances.
	`RID_ASSERT_NEXT(a_last_to_out, en && stage_valid[DW], out_valid_q,
		"last cell result lost")

endmodule
